/* rtl/ebml_enc_pkg.sv */
package ebml_enc_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [27:0] element_id;
      logic [55:0] length_value;
      logic [63:0] payload_number;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // operation codes
   localparam logic [1:0] OP_VINT   = 2'd0;
   localparam logic [1:0] OP_NUMBER = 2'd1;
   localparam logic [1:0] OP_HEADER = 2'd2;

   localparam logic [3:0] ID_CAP     = 4'd4;
   localparam logic [3:0] LV_CAP     = 4'd8;
   localparam logic [3:0] MAX_GROUPS = 4'd8;
   localparam logic [6:0] GROUP_ONES = 7'h7f;
   localparam logic [7:0] SIZE_MARK  = 8'h80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      FLD_ID,
      FLD_LV,
      FLD_PLEN,
      FLD_NUM
   } field_type;

   typedef struct packed {
      logic load;
      logic group8;
   } scan_ctrl_type;

   typedef struct packed {
      logic       done;
      logic [3:0] count;
      logic       ones;
   } scan_stat_type;

endpackage

/* rtl/ebml_enc_scan.sv */
module ebml_enc_scan
   import ebml_enc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scan_ctrl_type ctrl,
   input  logic [63:0]   src,
   output scan_stat_type stat
);

   logic [63:0] scan_ff, scan_in;
   logic [3:0]  count_ff, count_in;
   logic        ones_ff, ones_in;
   logic [63:0] shifted;

   // one group per cycle: 7 bits for vint values, 8 bits for payload bytes
   assign shifted = ctrl.group8 ? (scan_ff >> 8) : (scan_ff >> 7);

   always_comb begin
      stat.done  = (count_ff == MAX_GROUPS) || (shifted == 64'd0);
      stat.count = count_ff;
      stat.ones  = ones_ff;
      scan_in    = scan_ff;
      count_in   = count_ff;
      ones_in    = ones_ff;
      if (ctrl.load) begin
         scan_in  = src;
         count_in = 4'd1;
         ones_in  = (src[6:0] == GROUP_ONES);
      end else if (!stat.done) begin
         scan_in  = shifted;
         count_in = count_ff + 4'd1;
         ones_in  = ones_ff && (scan_ff[13:7] == GROUP_ONES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd1;
         ones_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ones_ff  <= ones_in;
      end
      scan_ff <= scan_in;
   end

endmodule

/* rtl/ebml_element_byte_encoder.sv */
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_type: op, element_id, length_value,
//                                           payload_number
// rsp      out        rsp_valid/rsp_stall   rsp_type: out_byte, last_byte
//
// one item at a time; each vint field is sized by the shared group scanner (one
// 7-bit or 8-bit group per cycle) and then sent one byte per cycle while rsp_stall is low.
// an item starts with the transfer in idle; each vint field then has a load step, a
// scan of its groups and then its bytes; payload bytes need no scan, only a load
// step and then their bytes. An unused op is taken in idle and starts nothing.
// req_stall is high from the transfer until the last byte is in the output
// register; rsp_stall holds the output register and pauses byte generation.
// reset is synchronous and returns the block to idle with no byte pending.
module ebml_element_byte_encoder
   import ebml_enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type     state_ff, state_in;
   field_type     fld_ff, fld_in;
   logic [1:0]    op_ff;
   logic [27:0]   id_ff;
   logic [55:0]   lv_ff;
   logic [63:0]   num_ff;
   logic [3:0]    p_ff, p_in;
   logic [63:0]   emit_ff, emit_in;
   logic [3:0]    rem_ff, rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   scan_ctrl_type scan_ctrl;
   scan_stat_type scan_stat;
   logic [63:0]   scan_src;
   logic          accept;
   logic          slot_free;
   logic          emit_fire;
   logic          final_fld;
   logic [3:0]    len_sum;
   logic [3:0]    len_cap;
   logic [3:0]    vint_len;
   logic [2:0]    byte_sel;
   logic [7:0]    cur_byte;

   ebml_enc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (scan_ctrl),
      .src   (scan_src),
      .stat  (scan_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (fld_ff)
         FLD_ID:   scan_src = {36'd0, id_ff};
         FLD_LV:   scan_src = {8'd0, lv_ff};
         default:  scan_src = num_ff;
      endcase
   end

   // vint length: groups used, one more when every group is all ones, then capped
   assign len_sum  = scan_stat.count + {3'd0, scan_stat.ones};
   assign len_cap  = (fld_ff == FLD_ID) ? ID_CAP : LV_CAP;
   assign vint_len = (len_sum > len_cap) ? len_cap : len_sum;

   assign final_fld = (fld_ff == FLD_LV) || (fld_ff == FLD_NUM);
   assign byte_sel  = 3'(rem_ff - 4'd1);
   assign cur_byte  = emit_ff[{byte_sel, 3'b000} +: 8];

   always_comb begin
      state_in         = state_ff;
      fld_in           = fld_ff;
      p_in             = p_ff;
      emit_in          = emit_ff;
      rem_in           = rem_ff;
      emit_fire        = 1'b0;
      scan_ctrl.load   = 1'b0;
      scan_ctrl.group8 = (fld_ff == FLD_PLEN);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.op)
                  OP_VINT: begin
                     fld_in   = FLD_LV;
                     state_in = ST_LOAD;
                  end
                  OP_NUMBER, OP_HEADER: begin
                     fld_in   = FLD_ID;
                     state_in = ST_LOAD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if (fld_ff == FLD_NUM) begin
               emit_in  = num_ff;
               rem_in   = p_ff;
               state_in = ST_EMIT;
            end else begin
               scan_ctrl.load = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               if (fld_ff == FLD_PLEN) begin
                  p_in    = scan_stat.count;
                  emit_in = {56'd0, SIZE_MARK | {4'd0, scan_stat.count}};
                  rem_in  = 4'd1;
               end else begin
                  emit_in = scan_src | (64'd1 << (6'(vint_len) * 6'd7));
                  rem_in  = vint_len;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               emit_fire = 1'b1;
               rem_in    = rem_ff - 4'd1;
               if (rem_ff == 4'd1) begin
                  if (final_fld) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_LOAD;
                     case (fld_ff)
                        FLD_ID:  fld_in = (op_ff == OP_NUMBER) ? FLD_PLEN : FLD_LV;
                        default: fld_in = FLD_NUM;
                     endcase
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = cur_byte;
         rsp_data_in.last_byte = final_fld && (rem_ff == 4'd1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fld_ff       <= FLD_ID;
         rem_ff       <= 4'd1;
         p_ff         <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fld_ff       <= fld_in;
         rem_ff       <= rem_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         op_ff  <= req_data.op;
         id_ff  <= req_data.element_id;
         lv_ff  <= req_data.length_value;
         num_ff <= req_data.payload_number;
      end
   end

   // the final byte of an item always returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && final_fld && (rem_ff == 4'd1)) |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after final byte");

   // a valid op starts a field load right after the transfer
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == OP_VINT || req_data.op == OP_NUMBER ||
                  req_data.op == OP_HEADER)) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not start");

   // bytes left to send stay within one 64-bit word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff >= 4'd1 && rem_ff <= 4'd8))
      else $error("byte count out of range");

   // scanned group count stays within eight groups
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_stat.count >= 4'd1 && scan_stat.count <= MAX_GROUPS))
      else $error("group count out of range");

endmodule
